/* sv/iba_pkg.sv */
// Shared types and codes for the bitmap identifier allocator.
package iba_pkg;

  localparam logic KIND_ALLOCATE = 1'b0;
  localparam logic KIND_RELEASE  = 1'b1;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_FULL    = 2'd1;
  localparam logic [1:0] STATUS_INVALID = 2'd2;

  typedef struct packed {
    logic       kind;
    logic [9:0] release_id;
  } req_t;

  typedef struct packed {
    logic [9:0] granted_id;
    logic [1:0] status;
  } rsp_t;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_GRANT,
    RES_FULL,
    RES_INVALID,
    RES_FREED
  } res_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic wr;
    res_t res;
  } cmd_t;

  typedef struct packed {
    logic release_req;
    logic bad;
    logic hit;
    logic last;
    logic out_free;
  } sts_t;

endpackage

/* sv/iba_datapath.sv */
// Bitmap word memory, scan address, first-free encoder and result register.
module iba_datapath #(
  parameter int MIN_ID = 100,
  parameter int MAX_ID = 1000
) (
  input  logic          clk,
  input  logic          rst,
  input  iba_pkg::req_t req,
  input  iba_pkg::cmd_t cmd,
  output iba_pkg::sts_t sts,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output iba_pkg::rsp_t rsp
);

  localparam int ID_COUNT  = MAX_ID - MIN_ID + 1;
  localparam int WORDS     = (ID_COUNT + 31) / 32;
  localparam int AW        = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int CW        = $clog2(WORDS + 1);
  localparam int LAST_BITS = ID_COUNT - 32 * (WORDS - 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(WORDS - 1);

  logic [31:0]   mem [0:WORDS-1];
  logic [31:0]   rd_data;
  logic          fresh;
  logic [AW-1:0] scan_addr;
  logic [AW-1:0] data_addr;
  logic [CW-1:0] hwm;
  logic          kind;
  logic          rel_bad;
  logic [4:0]    rel_bit;

  logic [31:0] rid_wide;
  logic [31:0] offset;
  logic [31:0] base;
  logic [31:0] pad;
  logic [31:0] used_eff;
  logic [31:0] new_word;
  logic [4:0]  fpos;
  logic        wr_en;
  logic [31:0] gid_sum;

  assign rid_wide = 32'(req.release_id);
  assign offset   = rid_wide - 32'(MIN_ID);
  assign base     = fresh ? '0 : rd_data;

  always_comb begin
    for (int i = 0; i < 32; i++) begin
      pad[i] = (data_addr == LAST_ADDR) && (i >= LAST_BITS);
    end
  end

  assign used_eff = base | pad;

  always_comb begin
    fpos = '0;
    for (int i = 31; i >= 0; i--) begin
      if (!used_eff[i]) begin
        fpos = 5'(i);
      end
    end
  end

  assign new_word = (kind == iba_pkg::KIND_ALLOCATE) ? (base | (32'd1 << fpos))
                                                     : (base & ~(32'd1 << rel_bit));
  assign wr_en    = cmd.wr && !((kind == iba_pkg::KIND_RELEASE) && fresh);
  assign gid_sum  = 32'(MIN_ID) + {(32 - AW - 5)'(0), data_addr, 5'b0} + 32'(fpos);

  // memory port
  always_ff @(posedge clk) begin
    if (cmd.rd && (scan_addr <= LAST_ADDR)) begin
      rd_data <= mem[scan_addr];
    end
    if (wr_en) begin
      mem[data_addr] <= new_word;
    end
  end

  // item and scan registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind      <= req.kind;
      rel_bad   <= (rid_wide < 32'(MIN_ID)) || (rid_wide > 32'(MAX_ID));
      rel_bit   <= offset[4:0];
      scan_addr <= (req.kind == iba_pkg::KIND_RELEASE) ? offset[AW+4:5] : '0;
    end else if (cmd.rd) begin
      scan_addr <= scan_addr + 1'b1;
    end
    if (cmd.rd) begin
      data_addr <= scan_addr;
      fresh     <= CW'(scan_addr) >= hwm;
    end
  end

  // words at or above hwm have never been written and read as all free
  always_ff @(posedge clk) begin
    if (rst) begin
      hwm <= '0;
    end else if (cmd.wr && (kind == iba_pkg::KIND_ALLOCATE) && fresh) begin
      hwm <= CW'(data_addr) + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.res != iba_pkg::RES_NONE) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.res)
      iba_pkg::RES_GRANT: begin
        rsp.granted_id <= gid_sum[9:0];
        rsp.status     <= iba_pkg::STATUS_OK;
      end
      iba_pkg::RES_FULL: begin
        rsp.granted_id <= '0;
        rsp.status     <= iba_pkg::STATUS_FULL;
      end
      iba_pkg::RES_INVALID: begin
        rsp.granted_id <= '0;
        rsp.status     <= iba_pkg::STATUS_INVALID;
      end
      iba_pkg::RES_FREED: begin
        rsp.granted_id <= '0;
        rsp.status     <= iba_pkg::STATUS_OK;
      end
      default: begin
      end
    endcase
  end

  assign sts.release_req = (kind == iba_pkg::KIND_RELEASE);
  assign sts.bad         = rel_bad;
  assign sts.hit         = ~&used_eff;
  assign sts.last        = (data_addr == LAST_ADDR);
  assign sts.out_free    = !rsp_valid || rsp_ready;

endmodule

/* sv/iba_ctrl.sv */
// Sequencer for allocate scans and releases.
module iba_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  iba_pkg::sts_t sts,
  output iba_pkg::cmd_t cmd
);

  typedef enum logic [7:0] {
    S_IDLE       = 8'b0000_0001,
    S_ISSUE      = 8'b0000_0010,
    S_SCAN       = 8'b0000_0100,
    S_REL        = 8'b0000_1000,
    S_POST_GRANT = 8'b0001_0000,
    S_POST_FULL  = 8'b0010_0000,
    S_POST_INV   = 8'b0100_0000,
    S_POST_FREED = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd.load   = 1'b0;
    cmd.rd     = 1'b0;
    cmd.wr     = 1'b0;
    cmd.res    = iba_pkg::RES_NONE;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_ISSUE;
        end
      end
      S_ISSUE: begin
        if (sts.release_req && sts.bad) begin
          state_next = S_POST_INV;
        end else begin
          cmd.rd     = 1'b1;
          state_next = sts.release_req ? S_REL : S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.hit) begin
          cmd.wr     = 1'b1;
          state_next = S_POST_GRANT;
        end else if (sts.last) begin
          state_next = S_POST_FULL;
        end else begin
          cmd.rd = 1'b1;
        end
      end
      S_REL: begin
        cmd.wr     = 1'b1;
        state_next = S_POST_FREED;
      end
      S_POST_GRANT: begin
        if (sts.out_free) begin
          cmd.res    = iba_pkg::RES_GRANT;
          state_next = S_IDLE;
        end
      end
      S_POST_FULL: begin
        if (sts.out_free) begin
          cmd.res    = iba_pkg::RES_FULL;
          state_next = S_IDLE;
        end
      end
      S_POST_INV: begin
        if (sts.out_free) begin
          cmd.res    = iba_pkg::RES_INVALID;
          state_next = S_IDLE;
        end
      end
      S_POST_FREED: begin
        if (sts.out_free) begin
          cmd.res    = iba_pkg::RES_FREED;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* sv/id_bitmap_allocator.sv */
// Top level of the bitmap identifier allocator: lowest-free allocate and release.
// Allocate: map words are read one per cycle through the single read port of the map
//   memory, from word 0 up to the first 32-bit word with a free bit (29 words for 901 ids),
//   whose lowest free bit is set; a full map ends after the last word. Release: read,
//   modify, write of one map word; an out-of-range release skips both and reports invalid.
// One item at a time; the next beat is taken in the cycle after the result is registered.
// Reset: controller idle, no result pending, map empty through a fill mark, no clearing pass.
module id_bitmap_allocator #(
  parameter int MIN_ID = 100,
  parameter int MAX_ID = 1000
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  iba_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output iba_pkg::rsp_t rsp
);

  iba_pkg::cmd_t cmd;
  iba_pkg::sts_t sts;

  iba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  iba_datapath #(
    .MIN_ID (MIN_ID),
    .MAX_ID (MAX_ID)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule
